// ----- rtl/spq_pkg.sv -----
// ============================================================================
// spq_pkg: shared definitions for the sorted priority queue
// Default sizes, request and status codes, sequencer states.
// ============================================================================
package spq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int ELEM_WIDTH_DEF = 32;
  localparam int PRIO_WIDTH_DEF = 16;

  // request codes
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ENQ,
    S_DEQ,
    S_RES
  } state_t;

endpackage

// ----- rtl/spq_req_if.sv -----
// ============================================================================
// spq_req_if: request channel
// Valid/ready handshake carrying one enqueue or dequeue request.
// ============================================================================
interface spq_req_if #(
  parameter int ELEM_WIDTH = spq_pkg::ELEM_WIDTH_DEF,
  parameter int PRIO_WIDTH = spq_pkg::PRIO_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [ELEM_WIDTH-1:0] elem_value;
  logic [PRIO_WIDTH-1:0] prio_value;

  modport source (output valid, req_type, elem_value, prio_value, input ready);
  modport sink   (input valid, req_type, elem_value, prio_value, output ready);
endinterface

// ----- rtl/spq_res_if.sv -----
// ============================================================================
// spq_res_if: result channel
// Valid/ready handshake carrying the queue state after one request.
// ============================================================================
interface spq_res_if #(
  parameter int ELEM_WIDTH = spq_pkg::ELEM_WIDTH_DEF,
  parameter int PRIO_WIDTH = spq_pkg::PRIO_WIDTH_DEF,
  parameter int CNT_WIDTH  = $clog2(spq_pkg::DEPTH_DEF + 1)
);
  logic                  valid;
  logic                  ready;
  logic [ELEM_WIDTH-1:0] head_elem;
  logic [PRIO_WIDTH-1:0] head_prio;
  logic [CNT_WIDTH-1:0]  entry_total;
  logic                  queue_empty;
  logic [1:0]            op_status;

  modport source (output valid, head_elem, head_prio, entry_total, queue_empty, op_status,
                  input ready);
  modport sink   (input valid, head_elem, head_prio, entry_total, queue_empty, op_status,
                  output ready);
endinterface

// ----- rtl/spq_ram.sv -----
// ============================================================================
// spq_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ============================================================================
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/sorted_priority_queue.sv -----
// ============================================================================
// sorted_priority_queue: bounded priority queue kept in descending order
// Enqueue scans the held entries tail first, moving each one it passes over
//   down one slot, and writes the new entry where the scan stops. Dequeue
//   shifts the remaining entries up one slot. Rejected requests skip the scan.
// Throughput: one request at a time, the next accepted once the result is loaded;
//   the scan/shift moves one entry per cycle over the single RAM port pair.
// Reset: rst (synchronous) empties the queue; slot contents are not cleared.
// ============================================================================
module sorted_priority_queue #(
  parameter int DEPTH      = spq_pkg::DEPTH_DEF,
  parameter int ELEM_WIDTH = spq_pkg::ELEM_WIDTH_DEF,
  parameter int PRIO_WIDTH = spq_pkg::PRIO_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  spq_req_if.sink     req,
  spq_res_if.source   res
);

  localparam int AW = $clog2(DEPTH);       // slot index width
  localparam int CW = $clog2(DEPTH + 1);   // entry count width
  localparam int EW = ELEM_WIDTH + PRIO_WIDTH;

  spq_pkg::state_t  state, state_next;
  spq_pkg::status_t status;

  logic [CW-1:0]         count;     // entries held, updated at accept
  logic [AW-1:0]         idx;       // slot being written by the scan
  logic [ELEM_WIDTH-1:0] new_elem;
  logic [PRIO_WIDTH-1:0] new_prio;
  logic [ELEM_WIDTH-1:0] head_elem;  // mirror of slot 0
  logic [PRIO_WIDTH-1:0] head_prio;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  logic                  accept;
  logic                  full;
  logic                  res_free;
  logic [PRIO_WIDTH-1:0] rd_prio;
  logic                  prio_hit;
  logic                  deq_last;

  assign accept   = req.valid && req.ready;
  assign full     = (count == CW'(DEPTH));
  assign res_free = !res.valid || res.ready;
  assign rd_prio  = ram_rdata[PRIO_WIDTH-1:0];
  // held entry of priority at least the new one stays ahead of it
  assign prio_hit = (rd_prio >= new_prio);
  // count is already decremented during the dequeue shift
  assign deq_last = ((CW'(idx) + CW'(1)) == count);

  // Entries stored as {elem, prio}
  spq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      spq_pkg::S_IDLE: begin
        if (accept) begin
          if (req.req_type == spq_pkg::REQ_ENQ) begin
            state_next = full ? spq_pkg::S_RES : spq_pkg::S_ENQ;
          end else begin
            // empty or single entry: nothing to shift
            state_next = (count <= CW'(1)) ? spq_pkg::S_RES : spq_pkg::S_DEQ;
          end
        end
      end
      spq_pkg::S_ENQ: begin
        if (idx == '0 || prio_hit) begin
          state_next = spq_pkg::S_RES;
        end
      end
      spq_pkg::S_DEQ: begin
        if (deq_last) begin
          state_next = spq_pkg::S_RES;
        end
      end
      spq_pkg::S_RES: begin
        if (res_free) begin
          state_next = spq_pkg::S_IDLE;
        end
      end
      default: state_next = spq_pkg::S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer outputs: RAM control and request ready.
  // Reads are issued one step ahead so a slot moves every cycle.
  // --------------------------------------------------------------------------
  always_comb begin
    req.ready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = ram_rdata;
    ram_raddr = '0;
    case (state)
      spq_pkg::S_IDLE: begin
        req.ready = 1'b1;
        // enqueue scans from the tail, dequeue shifts from slot 1
        ram_raddr = (req.req_type == spq_pkg::REQ_ENQ) ? AW'(count - CW'(1)) : AW'(1);
      end
      spq_pkg::S_ENQ: begin
        ram_we    = 1'b1;
        ram_raddr = idx - AW'(2);
        if (idx == '0 || prio_hit) begin
          ram_wdata = {new_elem, new_prio};
        end
      end
      spq_pkg::S_DEQ: begin
        ram_we    = 1'b1;
        ram_raddr = idx + AW'(2);
      end
      spq_pkg::S_RES: begin
        ram_we = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= spq_pkg::S_IDLE;
      count     <= '0;
      res.valid <= 1'b0;
    end else begin
      state <= state_next;

      if (accept) begin
        new_elem <= req.elem_value;
        new_prio <= req.prio_value;
        if (req.req_type == spq_pkg::REQ_ENQ) begin
          idx <= AW'(count);
          if (full) begin
            status <= spq_pkg::ST_FULL;
          end else begin
            status <= spq_pkg::ST_DONE;
            count  <= count + CW'(1);
          end
        end else begin
          idx <= '0;
          if (count == '0) begin
            status <= spq_pkg::ST_EMPTY;
          end else begin
            status <= spq_pkg::ST_DONE;
            count  <= count - CW'(1);
          end
        end
      end

      // step the scan: enqueue walks down, dequeue walks up
      if (state == spq_pkg::S_ENQ) begin
        idx <= idx - AW'(1);
      end
      if (state == spq_pkg::S_DEQ) begin
        idx <= idx + AW'(1);
      end

      // keep the head mirror in step with slot 0
      if (ram_we && ram_waddr == '0) begin
        head_elem <= ram_wdata[EW-1:PRIO_WIDTH];
        head_prio <= ram_wdata[PRIO_WIDTH-1:0];
      end

      // output register
      if (state == spq_pkg::S_RES && res_free) begin
        res.valid       <= 1'b1;
        res.head_elem   <= (count == '0) ? '0 : head_elem;
        res.head_prio   <= (count == '0) ? '0 : head_prio;
        res.entry_total <= count;
        res.queue_empty <= (count == '0);
        res.op_status   <= status;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && req.req_type == spq_pkg::REQ_ENQ && full) |=> (count == $past(count)))
    else $error("rejected enqueue changed the count");

  a_enq_idx: assert property (@(posedge clk) disable iff (rst)
    (state == spq_pkg::S_ENQ) |-> (CW'(idx) < count))
    else $error("enqueue scan index beyond held entries");

  a_deq_idx: assert property (@(posedge clk) disable iff (rst)
    (state == spq_pkg::S_DEQ) |-> ((CW'(idx) + CW'(1)) <= count))
    else $error("dequeue shift index beyond held entries");

  a_res_load: assert property (@(posedge clk) disable iff (rst)
    (state == spq_pkg::S_RES && res_free) |=> (res.valid && state == spq_pkg::S_IDLE))
    else $error("result not presented after request completed");

endmodule
